@@ sv/lenorm_pkg.sv @@
// Shared types, character constants and helpers for the line ending normaliser.
// Used by lenorm_match, lenorm_outbuf and the top; has no dependencies of its own.
`default_nettype none

package lenorm_pkg;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] PS_B0 = 8'hE2;
	localparam logic [7:0] PS_B1 = 8'h80;
	localparam logic [7:0] PS_B2 = 8'hA9;

	// Most words one input byte can produce.
	localparam int MaxWords = 3;
	localparam int CntW     = $clog2(MaxWords + 1);

	typedef enum logic [1:0] {
		PM_IDLE = 2'd0,
		PM_CR   = 2'd1,
		PM_E2   = 2'd2,
		PM_E280 = 2'd3
	} pend_t;

	// The group of words one input byte produces.
	typedef struct packed {
		logic [MaxWords-1:0][7:0] data;
		logic [CntW-1:0]          cnt;
		logic                     stream_end;
	} res_t;

	// Append one byte to a result group; extra bytes beyond capacity are dropped.
	function automatic res_t put_word(res_t r, logic [7:0] b);
		res_t o;
		o = r;
		if (r.cnt != CntW'(MaxWords)) begin
			o.data[r.cnt] = b;
			o.cnt         = r.cnt + CntW'(1);
		end
		return o;
	endfunction

endpackage

`default_nettype wire

@@ sv/lenorm_if.sv @@
// Valid/ready channel interfaces for the line ending normaliser.
// Depends on nothing; the byte input and the word output have one interface each.
`default_nettype none

interface lenorm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_stream_end;

	modport source (output valid, output in_byte, output in_stream_end, input ready);
	modport sink   (input valid, input in_byte, input in_stream_end, output ready);
endinterface

interface lenorm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       out_stream_end;

	modport source (output valid, output out_byte, output run_last,
		output out_stream_end, input ready);
	modport sink   (input valid, input out_byte, input run_last,
		input out_stream_end, output ready);
endinterface

`default_nettype wire

@@ sv/lenorm_match.sv @@
// Combinational match logic: from the held state and one byte, the words to emit
// and the next state. Depends on lenorm_pkg.
`default_nettype none

module lenorm_match
	import lenorm_pkg::*;
(
	input  pend_t      pend,
	input  logic [7:0] in_byte,
	input  logic       in_stream_end,
	output res_t       res,
	output pend_t      pend_nxt
);

	always_comb begin
		res_t  r;
		pend_t nxt;
		logic  do_idle;

		r          = '0;
		nxt        = PM_IDLE;
		do_idle    = 1'b0;

		unique case (pend)
			PM_CR: begin
				r = put_word(r, CH_LF);
				do_idle = (in_byte != CH_LF);
			end
			PM_E2: begin
				if (in_byte == PS_B1) begin
					nxt = PM_E280;
				end else begin
					r = put_word(r, PS_B0);
					do_idle = 1'b1;
				end
			end
			PM_E280: begin
				if (in_byte == PS_B2) begin
					r = put_word(r, CH_LF);
				end else begin
					r = put_word(r, PS_B0);
					r = put_word(r, PS_B1);
					do_idle = 1'b1;
				end
			end
			PM_IDLE: begin
				do_idle = 1'b1;
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase

		// A broken match is followed by the byte being handled from scratch.
		if (do_idle) begin
			priority if (in_byte == CH_CR) begin
				nxt = PM_CR;
			end else if (in_byte == PS_B0) begin
				nxt = PM_E2;
			end else begin
				r = put_word(r, in_byte);
			end
		end

		// At the end of the stream whatever is still held is flushed.
		if (in_stream_end) begin
			unique case (nxt)
				PM_CR:   r = put_word(r, CH_LF);
				PM_E2:   r = put_word(r, PS_B0);
				PM_E280: begin
					r = put_word(r, PS_B0);
					r = put_word(r, PS_B1);
				end
				default: ;
			endcase
			nxt = PM_IDLE;
		end

		r.stream_end = in_stream_end;
		res          = r;
		pend_nxt     = nxt;
	end

endmodule

`default_nettype wire

@@ sv/lenorm_outbuf.sv @@
// Result register: holds one byte's words, hands out one a cycle while ready is high.
// Depends on lenorm_pkg and lenorm_out_if.
`default_nettype none

module lenorm_outbuf
	import lenorm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  res_t             res,
	output logic             free,
	lenorm_out_if.source     result
);

	res_t            res_q;
	logic            valid_q;
	logic [CntW-1:0] idx_q;
	logic            last_word;
	logic            fire;

	assign last_word = (idx_q == res_q.cnt - CntW'(1));
	assign fire      = valid_q && result.ready;
	// The register can take the next group once its final word is taken.
	assign free      = !valid_q || (fire && last_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= (res.cnt != '0);
			idx_q   <= '0;
		end else if (fire) begin
			if (last_word) begin
				valid_q <= 1'b0;
			end
			idx_q <= idx_q + CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign result.valid          = valid_q;
	assign result.out_byte       = res_q.data[idx_q[$clog2(MaxWords)-1:0]];
	assign result.run_last       = last_word;
	assign result.out_stream_end = last_word && res_q.stream_end;

endmodule

`default_nettype wire

@@ sv/line_ending_normalizer.sv @@
// Top level of the line ending normaliser: input register, held match state,
// match logic and result register. Depends on lenorm_pkg, lenorm_if, lenorm_match, lenorm_outbuf.
//
// Turns a byte stream into one with LF line endings: CR LF and a lone CR become LF, and
// the paragraph separator E2 80 A9 becomes LF; other bytes pass unchanged. A byte is
// taken into an input register, run through the match logic against the held partial
// match, and its zero to three words land in a result register that hands out one word
// a cycle while the receiver is ready. A byte passes the input register, then the result register,
// before its first word shows; one yielding several words holds the result register until its
// last word is taken. The rate is one byte a cycle while each byte yields at most one word and
// the receiver is ready; a byte that yields none shows nothing. run_last marks the final word
// of each byte and out_stream_end the final word of the stream, after which a new stream starts.
`default_nettype none

module line_ending_normalizer
	import lenorm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	lenorm_in_if.sink    feed,
	lenorm_out_if.source result
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	pend_t      pend_q;
	pend_t      pend_nxt;
	res_t       res;
	logic       free;
	logic       move;

	assign move       = valid_s1 && free;
	assign feed.ready = !valid_s1 || move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_q   <= PM_IDLE;
		end else begin
			if (feed.ready) begin
				valid_s1 <= feed.valid;
			end
			if (move) begin
				pend_q <= pend_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (feed.valid && feed.ready) begin
			byte_s1 <= feed.in_byte;
			end_s1  <= feed.in_stream_end;
		end
	end

	lenorm_match u_match (
		.pend          (pend_q),
		.in_byte       (byte_s1),
		.in_stream_end (end_s1),
		.res           (res),
		.pend_nxt      (pend_nxt)
	);

	lenorm_outbuf u_outbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (move),
		.res    (res),
		.free   (free),
		.result (result)
	);

endmodule

`default_nettype wire

@@ sv/lenorm_checker.sv @@
// Port-level checks for the line ending normaliser, bound to the top level.
// Depends on line_ending_normalizer's channel ports only.
`default_nettype none

module lenorm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       in_stream_end,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       run_last,
	input wire logic       out_stream_end
);

	logic [1:0] end_cnt_q;
	logic       in_fire;
	logic       out_fire;
	logic       end_in;
	logic       end_out;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign end_in   = in_fire && in_stream_end;
	assign end_out  = out_fire && out_stream_end;

	// Counts accepted final bytes whose stream's final word has not left yet.
	// The input register and the result register hold at most two of them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_cnt_q <= '0;
		end else if (end_in && !end_out) begin
			end_cnt_q <= end_cnt_q + 2'd1;
		end else if (!end_in && end_out) begin
			end_cnt_q <= end_cnt_q - 2'd1;
		end
	end

	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte))
		else $error("output word changed while stalled");

	a_run_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && !run_last |=> out_valid)
		else $error("words of one byte were not delivered back to back");

	a_end_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_stream_end |-> end_cnt_q != 2'd0)
		else $error("stream end shown without an accepted final byte");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stream_end |-> run_last)
		else $error("stream end not on a closing word");

endmodule

bind line_ending_normalizer lenorm_checker u_lenorm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (feed.valid),
	.in_ready       (feed.ready),
	.in_stream_end  (feed.in_stream_end),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_byte       (result.out_byte),
	.run_last       (result.run_last),
	.out_stream_end (result.out_stream_end)
);

`default_nettype wire

@@ sim/line_ending_normalizer_test.sv @@
// Self-checking testbench for line_ending_normalizer: random and directed byte streams
// are predicted word by word and compared with the result channel.
// Depends on lenorm_pkg, lenorm_if and the line_ending_normalizer RTL.
`timescale 1ns / 100ps

module line_ending_normalizer_test;
	import lenorm_pkg::*;

	localparam int CycleLimit = 200000;

	// Predicts the normalised words for every accepted byte and checks the words that arrive.
	class lf_stream_checker;
		typedef struct packed {
			logic [7:0] data;
			logic       run_last;
			logic       stream_end;
		} word_t;

		word_t      due_words[$];
		logic [7:0] run_bytes[$];
		pend_t      held = PM_IDLE;
		int         errors = 0;

		function void queue_byte(logic [7:0] b);
			run_bytes = {run_bytes, b};
		endfunction

		function void fresh_byte(logic [7:0] b);
			if (b == CH_CR)
				held = PM_CR;
			else if (b == PS_B0)
				held = PM_E2;
			else
				queue_byte(b);
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			word_t w;
			run_bytes = {};
			case (held)
				PM_CR: begin
					held = PM_IDLE;
					queue_byte(CH_LF);
					if (b != CH_LF)
						fresh_byte(b);
				end
				PM_E2: begin
					if (b == PS_B1) begin
						held = PM_E280;
					end else begin
						held = PM_IDLE;
						queue_byte(PS_B0);
						fresh_byte(b);
					end
				end
				PM_E280: begin
					held = PM_IDLE;
					if (b == PS_B2) begin
						queue_byte(CH_LF);
					end else begin
						queue_byte(PS_B0);
						queue_byte(PS_B1);
						fresh_byte(b);
					end
				end
				default: begin
					held = PM_IDLE;
					fresh_byte(b);
				end
			endcase
			// The end of a stream flushes whatever partial match is still held.
			if (last) begin
				case (held)
					PM_CR:   queue_byte(CH_LF);
					PM_E2:   queue_byte(PS_B0);
					PM_E280: begin
						queue_byte(PS_B0);
						queue_byte(PS_B1);
					end
					default: ;
				endcase
				held = PM_IDLE;
			end
			foreach (run_bytes[i]) begin
				w.data       = run_bytes[i];
				w.run_last   = (i == run_bytes.size() - 1);
				w.stream_end = last && (i == run_bytes.size() - 1);
				due_words = {due_words, w};
			end
		endfunction

		function void check_word(logic [7:0] data, logic run_last, logic stream_end);
			word_t w;
			if (due_words.size() == 0) begin
				$display("%0t: unexpected word: actual %h run_last %b stream_end %b",
					$time, data, run_last, stream_end);
				errors++;
				return;
			end
			w = due_words.pop_front();
			if (data !== w.data) begin
				$display("%0t: out_byte mismatch: expected %h actual %h", $time, w.data, data);
				errors++;
			end
			if (run_last !== w.run_last) begin
				$display("%0t: run_last mismatch: expected %b actual %b",
					$time, w.run_last, run_last);
				errors++;
			end
			if (stream_end !== w.stream_end) begin
				$display("%0t: out_stream_end mismatch: expected %b actual %b",
					$time, w.stream_end, stream_end);
				errors++;
			end
		endfunction

		function int outstanding();
			return due_words.size();
		endfunction

		function void flag_leftover();
			if (due_words.size() != 0) begin
				$display("%0t: %0d expected words never arrived, next expected %h",
					$time, due_words.size(), due_words[0].data);
				errors += due_words.size();
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lenorm_in_if  feed_ch ();
	lenorm_out_if res_ch ();

	line_ending_normalizer dut (
		.clk   (clk),
		.arst_n(arst_n),
		.feed  (feed_ch.sink),
		.result(res_ch.source)
	);

	lf_stream_checker checker_sb = new;

	int  cycles = 0;
	int  sent_n = 0;
	bit  tx_idle_en = 1'b0;
	bit  rx_idle_en = 1'b0;
	bit  long_hold_req = 1'b0;
	int  rx_wait = 0;

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("line_ending_normalizer_test: done, errors");
			$finish;
		end
	end

	// Both monitors see the values from before the edge, so ordering within the step is moot.
	always @(posedge clk) begin
		if (arst_n && feed_ch.valid && feed_ch.ready)
			checker_sb.note_byte(feed_ch.in_byte, feed_ch.in_stream_end);
		if (arst_n && res_ch.valid && res_ch.ready)
			checker_sb.check_word(res_ch.out_byte, res_ch.run_last, res_ch.out_stream_end);
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			rx_wait = 120;
			res_ch.ready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			res_ch.ready <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
			rx_wait = $urandom_range(1, 15) - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		feed_ch.valid         <= 1'b1;
		feed_ch.in_byte       <= b;
		feed_ch.in_stream_end <= last;
		@(posedge clk);
		while (!feed_ch.ready)
			@(posedge clk);
		sent_n++;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			feed_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// One well-formed line ending, a broken one, or noise; any byte may end the stream.
	task automatic send_token();
		logic [7:0] seq[$];
		logic [7:0] specials[5];
		int         pick;
		specials = '{CH_CR, CH_LF, PS_B0, PS_B1, PS_B2};
		pick = $urandom_range(0, 99);
		if (pick < 30)
			seq = '{8'($urandom_range(0, 255))};
		else if (pick < 45)
			seq = '{CH_CR, CH_LF};
		else if (pick < 55)
			seq = '{CH_CR, 8'($urandom_range(32, 126))};
		else if (pick < 70)
			seq = '{PS_B0, PS_B1, PS_B2};
		else if (pick < 78)
			seq = '{PS_B0, 8'($urandom_range(0, 255))};
		else if (pick < 85)
			seq = '{PS_B0, PS_B1, 8'($urandom_range(0, 255))};
		else if (pick < 92)
			seq = '{specials[$urandom_range(0, 4)]};
		else
			seq = '{8'($urandom_range(32, 126))};
		foreach (seq[i])
			send_byte(seq[i], $urandom_range(0, 24) == 0);
	endtask

	task automatic drain_results();
		while (checker_sb.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n                <= 1'b0;
		feed_ch.valid         <= 1'b0;
		feed_ch.in_byte       <= 8'h00;
		feed_ch.in_stream_end <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rx_idle_en = 1'b1;
		tx_idle_en = 1'b1;

		// Extremes, every kind of line ending, broken matches and flushes at stream end.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(PS_B0, 1'b0);
		send_byte(PS_B1, 1'b0);
		send_byte(PS_B2, 1'b0);
		send_byte(PS_B0, 1'b0);
		send_byte(PS_B0, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(PS_B0, 1'b0);
		send_byte(PS_B1, 1'b0);
		send_byte(CH_CR, 1'b1);
		send_byte(PS_B0, 1'b0);
		send_byte(PS_B1, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(PS_B0, 1'b1);
		send_byte(PS_B0, 1'b0);
		send_byte(PS_B1, 1'b1);
		send_byte(CH_LF, 1'b1);
		send_byte(PS_B1, 1'b0);
		send_byte(PS_B2, 1'b1);

		while (sent_n < 90)
			send_token();

		// The receiver holds off while the bytes keep coming, so the input has to stall.
		tx_idle_en    = 1'b0;
		long_hold_req = 1'b1;
		while (sent_n < 115)
			send_token();
		feed_ch.valid <= 1'b0;
		drain_results();
		tx_idle_en = 1'b1;

		while (sent_n < 145)
			send_token();

		rx_idle_en = 1'b0;
		tx_idle_en = 1'b0;
		while (sent_n < 179)
			send_token();
		send_byte(8'($urandom_range(0, 255)), 1'b1);
		feed_ch.valid <= 1'b0;

		drain_results();
		repeat (10) @(posedge clk);
		checker_sb.flag_leftover();
		if (checker_sb.errors == 0)
			$display("line_ending_normalizer_test: done, clean");
		else
			$display("line_ending_normalizer_test: done, errors");
		$finish;
	end

endmodule

@@ line_ending_normalizer.f @@
sv/lenorm_pkg.sv
sv/lenorm_if.sv
sv/lenorm_match.sv
sv/lenorm_outbuf.sv
sv/line_ending_normalizer.sv
sv/lenorm_checker.sv
sim/line_ending_normalizer_test.sv
